>>> hdl/acpg_pkg.sv
package acpg_pkg;

  // Default number of bytes of one command line that are kept.
  localparam int unsigned LineLimitDefault = 29;

  // Character codes used by the line parser.
  localparam logic [7:0] CharEquals = 8'h3D;  // '='
  localparam logic [7:0] CharZero   = 8'h30;  // '0'
  localparam logic [7:0] CharNine   = 8'h39;  // '9'
  localparam logic [7:0] CharPeriod = 8'h61;  // 'a'
  localparam logic [7:0] CharDuty   = 8'h62;  // 'b'
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharLf     = 8'h0A;

  // Kinds of input request.
  localparam logic ActionByte = 1'b0;
  localparam logic ActionTick = 1'b1;

  // Values after reset.
  localparam logic [15:0] PeriodReset = 16'd100;
  localparam logic [15:0] DutyReset   = 16'd40;

endpackage

>>> hdl/ascii_command_pwm_generator.sv
// Channel | Direction | Handshake                | Payload
// --------+-----------+--------------------------+------------------------------------------
// in      | input     | in_valid_i / in_ready_o  | action_i, rx_byte_i
// out     | output    | out_valid_o / out_ready_i| pwm_out_o, period_value_o, duty_value_o
//
// One request is accepted per cycle unless the consumer stalls, and every request
// produces exactly one result. A request is first held in the input register; the
// parser, the tick counter and the result register are then updated together when
// the request moves on into the result stage, which then presents its result.
// The input register and the result register act as two stages, so a request is
// still taken while a finished result waits for the consumer.
// Reset clears the line state, sets the period to 100 and the duty to 40 and
// clears the tick counter and the PWM level.
// When the consumer stalls, at most one further request is held in the input register.
module ascii_command_pwm_generator #(
  parameter int unsigned LINE_LIMIT = acpg_pkg::LineLimitDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pwm_out_o,
  output logic [15:0] period_value_o,
  output logic [15:0] duty_value_o
);

  // The line count saturates at LINE_LIMIT, so it needs room for that value.
  localparam int unsigned LcW = $clog2(LINE_LIMIT + 1);
  localparam logic [LcW-1:0] LineLimitC = LcW'(LINE_LIMIT);

  // Input register stage.
  logic       in_valid_q;
  logic       action_q;
  logic [7:0] byte_q;

  // Result stage: the state registers double as the result payload, since
  // they change only when a new result is loaded.
  logic out_valid_q;
  logic advance;

  // Parser and PWM state.
  logic [LcW-1:0] line_count_q, line_count_d;
  logic [7:0]     first_char_q, first_char_d;
  logic           seen_equals_q, seen_equals_d;
  logic           digits_open_q, digits_open_d;
  logic [15:0]    number_accum_q, number_accum_d;
  logic [15:0]    period_q, period_d;
  logic [15:0]    duty_q, duty_d;
  logic [15:0]    tick_count_q, tick_count_d;
  logic           pwm_level_q, pwm_level_d;

  logic        is_term;
  logic        is_digit;
  logic [3:0]  digit_full;
  logic [15:0] accum_times_ten;
  logic [15:0] tick_inc;

  // The result stage moves on when it is empty or its result is being taken;
  // the input stage then drains into it.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload of the input stage needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      action_q <= action_i;
      byte_q   <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Byte classification and the decimal step (x * 10 = x * 8 + x * 2).
  assign is_term         = (byte_q == acpg_pkg::CharCr) || (byte_q == acpg_pkg::CharLf);
  assign is_digit        = (byte_q >= acpg_pkg::CharZero) && (byte_q <= acpg_pkg::CharNine);
  assign digit_full      = 4'(byte_q - acpg_pkg::CharZero);
  assign accum_times_ten = (number_accum_q << 3) + (number_accum_q << 1);

  // The tick counter wraps at 16 bits before it is compared with the period.
  assign tick_inc = tick_count_q + 16'd1;

  always_comb begin
    line_count_d   = line_count_q;
    first_char_d   = first_char_q;
    seen_equals_d  = seen_equals_q;
    digits_open_d  = digits_open_q;
    number_accum_d = number_accum_q;
    period_d       = period_q;
    duty_d         = duty_q;
    tick_count_d   = tick_count_q;
    pwm_level_d    = pwm_level_q;

    if (action_q == acpg_pkg::ActionTick) begin
      // A zero period keeps the counter at zero on every tick.
      tick_count_d = (tick_inc >= period_q) ? 16'd0 : tick_inc;
      pwm_level_d  = tick_count_d < duty_q;
    end else if (is_term) begin
      // A terminator applies the number only if the line held an '='.
      if (seen_equals_q) begin
        if (first_char_q == acpg_pkg::CharPeriod) begin
          period_d = number_accum_q;
        end else if (first_char_q == acpg_pkg::CharDuty) begin
          duty_d = number_accum_q;
        end
      end
      line_count_d   = '0;
      first_char_d   = '0;
      seen_equals_d  = 1'b0;
      digits_open_d  = 1'b0;
      number_accum_d = '0;
    end else if (line_count_q < LineLimitC) begin
      // Bytes past the limit are dropped without effect.
      if (line_count_q == '0) begin
        first_char_d = byte_q;
      end
      line_count_d = line_count_q + LcW'(1);
      if (!seen_equals_q) begin
        if (byte_q == acpg_pkg::CharEquals) begin
          seen_equals_d  = 1'b1;
          digits_open_d  = 1'b1;
          number_accum_d = '0;
        end
      end else if (digits_open_q) begin
        if (is_digit) begin
          number_accum_d = accum_times_ten + {12'd0, digit_full};
        end else begin
          digits_open_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q   <= '0;
      first_char_q   <= '0;
      seen_equals_q  <= 1'b0;
      digits_open_q  <= 1'b0;
      number_accum_q <= '0;
      period_q       <= acpg_pkg::PeriodReset;
      duty_q         <= acpg_pkg::DutyReset;
      tick_count_q   <= '0;
      pwm_level_q    <= 1'b0;
    end else if (advance) begin
      line_count_q   <= line_count_d;
      first_char_q   <= first_char_d;
      seen_equals_q  <= seen_equals_d;
      digits_open_q  <= digits_open_d;
      number_accum_q <= number_accum_d;
      period_q       <= period_d;
      duty_q         <= duty_d;
      tick_count_q   <= tick_count_d;
      pwm_level_q    <= pwm_level_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_out_o      = pwm_level_q;
  assign period_value_o = period_q;
  assign duty_value_o   = duty_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_count_q <= LineLimitC)
    else $error("line count beyond its limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_open_q |-> seen_equals_q)
    else $error("digits open without an equals sign");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && action_q == acpg_pkg::ActionByte) |=>
      ($stable(tick_count_q) && $stable(pwm_level_q)))
    else $error("byte request changed the PWM state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(period_q) && $stable(duty_q) && $stable(pwm_level_q)))
    else $error("result changed without a new request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled while the pipeline could move");
`endif

endmodule

>>> tb/tb_ascii_command_pwm_generator.sv
`timescale 1ns / 1ps

module tb_ascii_command_pwm_generator;

  localparam int unsigned LineLimit   = acpg_pkg::LineLimitDefault;
  localparam int          CycleLimit  = 200000;
  localparam int          DrainCycles = 20;

  // The three fields of one result, bundled so that a whole expectation can
  // wait in a single queue.
  typedef struct packed {
    logic        pwm;
    logic [15:0] period;
    logic [15:0] duty;
  } pwm_status_t;

  // Tracks the command-line parser and the PWM counter, and keeps the
  // results that are still owed by the block, oldest first.
  class pwm_status_tracker;
    int unsigned kept_bytes;
    logic [7:0]  head_char;
    logic        equals_seen;
    logic        reading_digits;
    logic [15:0] parsed_number;
    logic [15:0] period_q;
    logic [15:0] duty_q;
    logic [15:0] tick_count;
    logic        level;
    pwm_status_t owed_results[$];
    int          mismatches;

    function new();
      kept_bytes     = 0;
      head_char      = '0;
      equals_seen    = 1'b0;
      reading_digits = 1'b0;
      parsed_number  = '0;
      period_q       = acpg_pkg::PeriodReset;
      duty_q         = acpg_pkg::DutyReset;
      tick_count     = '0;
      level          = 1'b0;
      mismatches     = 0;
    endfunction

    // Updates the tracked state for one accepted request and queues the
    // result that the block owes for it.
    function void note_request(logic act, logic [7:0] rx);
      pwm_status_t st;
      if (act == acpg_pkg::ActionTick) begin
        tick_count = tick_count + 16'd1;
        if (tick_count >= period_q) tick_count = '0;
        level = (tick_count < duty_q);
      end else if (rx == acpg_pkg::CharCr || rx == acpg_pkg::CharLf) begin
        if (equals_seen) begin
          if (head_char == acpg_pkg::CharPeriod) period_q = parsed_number;
          else if (head_char == acpg_pkg::CharDuty) duty_q = parsed_number;
        end
        kept_bytes     = 0;
        head_char      = '0;
        equals_seen    = 1'b0;
        reading_digits = 1'b0;
        parsed_number  = '0;
      end else if (kept_bytes < LineLimit) begin
        if (kept_bytes == 0) head_char = rx;
        kept_bytes++;
        if (!equals_seen) begin
          if (rx == acpg_pkg::CharEquals) begin
            equals_seen    = 1'b1;
            reading_digits = 1'b1;
            parsed_number  = '0;
          end
        end else if (reading_digits) begin
          if (rx >= acpg_pkg::CharZero && rx <= acpg_pkg::CharNine)
            parsed_number = parsed_number * 16'd10 + {8'd0, rx - acpg_pkg::CharZero};
          else
            reading_digits = 1'b0;
        end
      end
      st.pwm    = level;
      st.period = period_q;
      st.duty   = duty_q;
      owed_results.push_back(st);
    endfunction

    function void check_result(logic pwm, logic [15:0] period, logic [15:0] duty);
      pwm_status_t want;
      if (owed_results.size() == 0) begin
        $error("result arrived with no request outstanding: pwm_out %0d period %0d duty %0d",
               pwm, period, duty);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (pwm !== want.pwm) begin
        $error("pwm_out: expected %0d, actual %0d", want.pwm, pwm);
        mismatches++;
      end
      if (period !== want.period) begin
        $error("period_value: expected %0d, actual %0d", want.period, period);
        mismatches++;
      end
      if (duty !== want.duty) begin
        $error("duty_value: expected %0d, actual %0d", want.duty, duty);
        mismatches++;
      end
    endfunction

    function int owed_count();
      return owed_results.size();
    endfunction
  endclass

  // Every input is held at a known value from time zero; reset starts low.
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        action_i    = acpg_pkg::ActionByte;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        pwm_out_o;
  logic [15:0] period_value_o;
  logic [15:0] duty_value_o;

  pwm_status_tracker tracker = new();

  // Percentages of cycles in which the sender and the receiver hold back.
  int send_idle_pct = 6;
  int recv_idle_pct = 81;
  int requests_sent = 0;
  int cycle_count   = 0;

  ascii_command_pwm_generator #(
    .LINE_LIMIT(LineLimit)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pwm_out_o      (pwm_out_o),
    .period_value_o (period_value_o),
    .duty_value_o   (duty_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one request, possibly after a random gap, and holds it steady
  // until the block takes it. Handshake signals are sampled at the edge, so
  // they carry their values from before the edge.
  task automatic send_request(input logic act, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.note_request(act, rx);
    requests_sent++;
  endtask

  // The byte field is irrelevant on a tick, so it carries noise.
  task automatic send_ticks(input int count);
    for (int i = 0; i < count; i++)
      send_request(acpg_pkg::ActionTick, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(acpg_pkg::ActionByte, s[i]);
  endtask

  // Any byte that does not end the line.
  function automatic logic [7:0] line_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == acpg_pkg::CharCr || b == acpg_pkg::CharLf);
    return b;
  endfunction

  // Builds one command line with random content. Most lines are well formed
  // "a=N" or "b=N" commands with small numbers so that the PWM output keeps
  // toggling; some pad the line past the kept length, drop the '=', leave
  // out the digits, carry long digit runs that wrap, or start with another
  // character altogether.
  task automatic send_command_line();
    logic [7:0] line_q[$];
    int         pick;
    int         pad;
    string      digits;
    pick = $urandom_range(9);
    if (pick < 4) line_q.push_back(acpg_pkg::CharPeriod);
    else if (pick < 8) line_q.push_back(acpg_pkg::CharDuty);
    else line_q.push_back(line_byte());
    pad = ($urandom_range(11) == 0) ? $urandom_range(20, 35) : $urandom_range(0, 2);
    repeat (pad) line_q.push_back(8'($urandom_range(8'h63, 8'h7A)));
    if ($urandom_range(9) != 0) line_q.push_back(acpg_pkg::CharEquals);
    pick = $urandom_range(19);
    if (pick < 14) digits = $sformatf("%0d", $urandom_range(0, 40));
    else if (pick < 17) digits = $sformatf("%0d", $urandom_range(0, 65535));
    else if (pick == 17) digits = "";
    else begin
      digits = "";
      repeat ($urandom_range(6, 9)) digits = {digits, $sformatf("%0d", $urandom_range(9))};
    end
    for (int i = 0; i < digits.len(); i++) line_q.push_back(digits[i]);
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) line_q.push_back(line_byte());
    line_q.push_back($urandom_range(1) ? acpg_pkg::CharCr : acpg_pkg::CharLf);
    foreach (line_q[i]) send_request(acpg_pkg::ActionByte, line_q[i]);
  endtask

  // Random traffic until the running request count reaches the target.
  // Command lines and bursts of ticks make up the bulk; now and then a few
  // wholly random requests break into a line.
  task automatic run_random(input int target);
    while (requests_sent < target) begin
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 5))
          send_request(logic'($urandom_range(1)), 8'($urandom_range(255)));
      end else begin
        send_command_line();
        send_ticks($urandom_range(0, 40));
      end
    end
  endtask

  // The receiver: a result is taken on an edge where both valid and ready
  // were high, and ready for the next cycle is drawn afresh.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_result(pwm_out_o, period_value_o, duty_value_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_ascii_command_pwm_generator: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a tick from reset, a duty command without digits, a
    // zero period, a line whose first character selects nothing, the byte
    // extremes inside a line, an empty line, then a duty above a zero period.
    send_ticks(1);
    send_text("b=");
    send_request(acpg_pkg::ActionByte, acpg_pkg::CharCr);
    send_ticks(1);
    send_text("a=0\n");
    send_ticks(1);
    send_text("c=7");
    send_request(acpg_pkg::ActionByte, acpg_pkg::CharCr);
    send_request(acpg_pkg::ActionByte, 8'h00);
    send_request(acpg_pkg::ActionByte, 8'hFF);
    send_request(acpg_pkg::ActionByte, acpg_pkg::CharLf);
    send_request(acpg_pkg::ActionByte, acpg_pkg::CharCr);
    send_text("b=99\n");
    send_ticks(2);

    // Random part in three phases of idling: a slow receiver, then a slow
    // sender, then both at full rate.
    run_random(requests_sent + 350);
    send_idle_pct = 81;
    recv_idle_pct = 6;
    run_random(requests_sent + 350);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(requests_sent + 350);
    in_valid_i <= 1'b0;

    // Let every owed result come back, then watch a little longer for any
    // stray result.
    while (tracker.owed_count() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("tb_ascii_command_pwm_generator: PASS");
    end else begin
      $display("tb_ascii_command_pwm_generator: FAIL");
    end
    $finish;
  end

endmodule
